>>> rtl/core/routing_table_engine_unit_defines.svh
// Assertion macros for the routing table engine.
// Included by the top level only; define NO_ASSERTIONS to compile them out.
`ifndef ROUTING_TABLE_ENGINE_UNIT_DEFINES_SVH
`define ROUTING_TABLE_ENGINE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define RTE_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
// Next-cycle implication, checked out of reset.
`define RTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define RTE_ASSERT(label, ante, cons)
`define RTE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/core/rte_pkg.sv
// Shared types and codes for the routing table engine.
// No dependencies; used by rte_cmp and routing_table_engine_unit.
package rte_pkg;

    typedef enum logic [1:0] {
        OP_LOOKUP   = 2'd0,
        OP_ADD      = 2'd1,
        OP_DEL_DEST = 2'd2,
        OP_DEL_HOP  = 2'd3
    } op_t;

    localparam int ADDR_W = 8;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] dest_addr;
        logic [ADDR_W-1:0] hop_addr;
    } route_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] next_hop;
        logic              hit;
        logic              table_full;
    } route_rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] hop;
    } entry_t;

    // Verdict of the compare unit on one table entry.
    typedef struct packed {
        logic match;   // entry counts as a hit for this op
        logic stop;    // end the scan at this entry
        logic fill;    // write request into this entry
        logic clear;   // empty this entry
    } cmp_res_t;

endpackage

>>> rtl/core/rte_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rte_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/rte_cmp.sv
// Shared compare unit: judges one table entry against the current request.
// Depends on rte_pkg.
module rte_cmp (
    input  rte_pkg::route_req_t req,
    input  logic                entry_valid,
    input  rte_pkg::entry_t     entry,
    output rte_pkg::cmp_res_t   res
);

    logic dest_eq;
    logic hop_eq;

    assign dest_eq = entry_valid && (entry.dest == req.dest_addr);
    assign hop_eq  = entry_valid && (entry.hop == req.hop_addr);

    always_comb
    begin
        res = '0;
        case (req.op)
            rte_pkg::OP_LOOKUP:
            begin
                res.match = dest_eq;
                res.stop  = dest_eq;
            end
            rte_pkg::OP_ADD:
            begin
                // first entry that matches or is empty takes the add
                res.match = dest_eq || !entry_valid;
                res.stop  = dest_eq || !entry_valid;
                res.fill  = dest_eq || !entry_valid;
            end
            rte_pkg::OP_DEL_DEST:
            begin
                res.match = dest_eq;
                res.stop  = dest_eq;
                res.clear = dest_eq;
            end
            rte_pkg::OP_DEL_HOP:
            begin
                res.match = hop_eq;
                res.clear = hop_eq;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/routing_table_engine_unit.sv
// Top level of the next-hop routing table: scan sequencer, entry RAM, valid bits.
// Depends on rte_pkg, rte_ram, rte_cmp and routing_table_engine_unit_defines.svh.
//
//  channel   handshake         payload          notes
//  request   start / busy      req (route_req)  taken when start && !busy
//  result    done (strobe)     rsp (route_rsp)  one cycle, cannot be held off
//
// One entry is read and judged per cycle by the shared compare unit; the RAM
// read port sets the pace. A request with destination 0 (not a hop purge)
// answers in the cycle after it is taken; any other scans from entry 0 to its
// stop entry or the last entry. Reset clears all valid bits at once, so the
// table is empty right after reset with no clearing pass. busy stays high for
// the whole scan; the result register frees the block in the cycle done shows.
`include "routing_table_engine_unit_defines.svh"

module routing_table_engine_unit #(
    parameter int ROUTE_ENTRIES = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  rte_pkg::route_req_t req,
    output logic                done,
    output rte_pkg::route_rsp_t rsp
);

    localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUTE_ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t                   state_reg, state_next;
    rte_pkg::route_req_t      req_reg, req_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic                     hit_acc_reg, hit_acc_next;
    logic [ROUTE_ENTRIES-1:0] valid_reg, valid_next;
    logic                     done_reg, done_next;
    rte_pkg::route_rsp_t      rsp_reg, rsp_next;

    logic                     ram_wr_en;
    rte_pkg::entry_t          ram_wr_data;
    logic                     ram_rd_en;
    logic [IDX_W-1:0]         ram_rd_addr;
    rte_pkg::entry_t          ram_rd_data;
    rte_pkg::cmp_res_t        cmp;
    logic                     last_entry;

    rte_ram #(
        .WIDTH  ($bits(rte_pkg::entry_t)),
        .DEPTH  (ROUTE_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (idx_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    rte_cmp u_cmp (
        .req         (req_reg),
        .entry_valid (valid_reg[idx_reg]),
        .entry       (ram_rd_data),
        .res         (cmp)
    );

    assign last_entry  = (idx_reg == LAST_IDX);
    assign ram_wr_data = '{dest: req_reg.dest_addr, hop: req_reg.hop_addr};

    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        idx_next     = idx_reg;
        hit_acc_next = hit_acc_reg;
        valid_next   = valid_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        ram_wr_en    = 1'b0;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next     = req;
                    idx_next     = '0;
                    hit_acc_next = 1'b0;
                    // destination 0 is the empty mark: answer at once
                    if ((req.op != rte_pkg::OP_DEL_HOP) && (req.dest_addr == '0))
                    begin
                        done_next = 1'b1;
                        rsp_next  = '0;
                    end
                    else
                    begin
                        ram_rd_en  = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (cmp.clear)
                begin
                    valid_next[idx_reg] = 1'b0;
                end
                if (cmp.fill)
                begin
                    ram_wr_en           = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                end
                if (cmp.match)
                begin
                    hit_acc_next = 1'b1;
                end

                if (cmp.stop || last_entry)
                begin
                    done_next           = 1'b1;
                    state_next          = ST_IDLE;
                    rsp_next.next_hop   = (req_reg.op == rte_pkg::OP_LOOKUP && cmp.stop) ?
                                          ram_rd_data.hop : '0;
                    rsp_next.hit        = cmp.match || hit_acc_reg;
                    rsp_next.table_full = (req_reg.op == rte_pkg::OP_ADD) && !cmp.stop;
                end
                else
                begin
                    // advance: fetch the next entry while this one is judged
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_reg + 1'b1;
                    idx_next    = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            hit_acc_reg <= 1'b0;
            valid_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            hit_acc_reg <= hit_acc_next;
            valid_reg   <= valid_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg == ST_SCAN);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // an accepted transaction either scans or answers in the next cycle
    `RTE_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done)
    // a full report only comes from an add against a table with no empty entry
    `RTE_ASSERT(a_full_only_when_full, done && rsp.table_full,
        (&valid_reg) && (req_reg.op == rte_pkg::OP_ADD) && !rsp.hit)
    // a nonzero hop is only returned by a lookup hit
    `RTE_ASSERT(a_hop_from_lookup, done && (rsp.next_hop != '0),
        (req_reg.op == rte_pkg::OP_LOOKUP) && rsp.hit)

endmodule

>>> test/tb_routing_table_engine_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for routing_table_engine_unit: directed and random table operations,
// each predicted by a behavioral table model and checked against the strobed response.
// Depends on rte_pkg and the routing_table_engine_unit RTL.
module tb_routing_table_engine_unit;

    localparam int ROUTE_ENTRIES = 8;
    localparam int RANDOM_PER_PHASE = 400;
    localparam int ADDR_W = rte_pkg::ADDR_W;

    typedef enum int unsigned {
        MIX_FILL,
        MIX_CHURN,
        MIX_EVEN
    } mix_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    rte_pkg::route_req_t req = '0;
    logic                done;
    rte_pkg::route_rsp_t rsp;

    // Behavioral copy of the table
    logic [ADDR_W-1:0] route_dest [ROUTE_ENTRIES];
    logic [ADDR_W-1:0] route_hop  [ROUTE_ENTRIES];

    rte_pkg::route_req_t req_pending_q [$];
    rte_pkg::route_rsp_t rsp_expect_q [$];
    int unsigned send_gap_pct = 32;
    int unsigned err_count = 0;
    int unsigned txn_count = 0;
    int unsigned op_count [4] = '{0, 0, 0, 0};
    int unsigned hit_count = 0;
    int unsigned full_count = 0;

    routing_table_engine_unit #(
        .ROUTE_ENTRIES(ROUTE_ENTRIES)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .req  (req),
        .done (done),
        .rsp  (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Apply one operation to the table copy and return the response it produces.
    function automatic rte_pkg::route_rsp_t route_apply(input rte_pkg::route_req_t r);
        rte_pkg::route_rsp_t o;
        logic                found;
        int                  i;
        o = '0;
        found = 1'b0;
        case (r.op)
            rte_pkg::OP_LOOKUP:
            begin
                if (r.dest_addr != '0)
                begin
                    for (i = 0; i < ROUTE_ENTRIES; i++)
                    begin
                        if (!found && route_dest[i] == r.dest_addr)
                        begin
                            o.next_hop = route_hop[i];
                            o.hit = 1'b1;
                            found = 1'b1;
                        end
                    end
                end
            end
            rte_pkg::OP_ADD:
            begin
                if (r.dest_addr != '0)
                begin
                    o.table_full = 1'b1;
                    // stop at the first match or empty slot, whichever comes first
                    for (i = 0; i < ROUTE_ENTRIES; i++)
                    begin
                        if (!found && (route_dest[i] == r.dest_addr || route_dest[i] == '0))
                        begin
                            route_dest[i] = r.dest_addr;
                            route_hop[i] = r.hop_addr;
                            o.hit = 1'b1;
                            o.table_full = 1'b0;
                            found = 1'b1;
                        end
                    end
                end
            end
            rte_pkg::OP_DEL_DEST:
            begin
                if (r.dest_addr != '0)
                begin
                    for (i = 0; i < ROUTE_ENTRIES; i++)
                    begin
                        if (!found && route_dest[i] == r.dest_addr)
                        begin
                            route_dest[i] = '0;
                            route_hop[i] = '0;
                            o.hit = 1'b1;
                            found = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                for (i = 0; i < ROUTE_ENTRIES; i++)
                begin
                    if (route_dest[i] != '0 && route_hop[i] == r.hop_addr)
                    begin
                        route_dest[i] = '0;
                        route_hop[i] = '0;
                        o.hit = 1'b1;
                    end
                end
            end
        endcase
        return o;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_dest();
        int unsigned pick;
        pick = $urandom_range(99);
        // mostly a small pool so entries collide, fill up and get found again
        if (pick < 75)
            return ADDR_W'($urandom_range(1, 12));
        else if (pick < 80)
            return '0;
        else
            return ADDR_W'($urandom_range(255));
    endfunction

    function automatic logic [ADDR_W-1:0] rand_hop();
        if ($urandom_range(99) < 60)
            return ADDR_W'($urandom_range(3));
        else
            return ADDR_W'($urandom_range(255));
    endfunction

    function automatic rte_pkg::route_req_t rand_route_req(input mix_t mix);
        rte_pkg::route_req_t r;
        int unsigned         pick;
        pick = $urandom_range(99);
        case (mix)
            MIX_FILL:
                r.op = (pick < 70) ? rte_pkg::OP_ADD : (pick < 90) ? rte_pkg::OP_LOOKUP :
                       (pick < 96) ? rte_pkg::OP_DEL_DEST : rte_pkg::OP_DEL_HOP;
            MIX_CHURN:
                r.op = (pick < 20) ? rte_pkg::OP_ADD : (pick < 40) ? rte_pkg::OP_LOOKUP :
                       (pick < 80) ? rte_pkg::OP_DEL_DEST : rte_pkg::OP_DEL_HOP;
            default:
                r.op = rte_pkg::op_t'($urandom_range(3));
        endcase
        r.dest_addr = rand_dest();
        r.hop_addr = rand_hop();
        return r;
    endfunction

    task automatic push_req(input rte_pkg::op_t op, input logic [ADDR_W-1:0] dest,
                            input logic [ADDR_W-1:0] hop);
        rte_pkg::route_req_t r;
        r.op = op;
        r.dest_addr = dest;
        r.hop_addr = hop;
        req_pending_q.push_back(r);
    endtask

    // Queue random bursts, each with its own operation mix.
    task automatic queue_random(input int unsigned count);
        int unsigned n;
        int unsigned len;
        int unsigned j;
        mix_t        mix;
        n = 0;
        while (n < count)
        begin
            mix = mix_t'($urandom_range(2));
            len = $urandom_range(8, 24);
            for (j = 0; j < len && n < count; j++)
            begin
                req_pending_q.push_back(rand_route_req(mix));
                n++;
            end
        end
    endtask

    task automatic drain_requests();
        while (req_pending_q.size() != 0 || start)
            @(negedge clk);
    endtask

    // Driver: hold start until taken, then idle at random before the next transaction.
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        logic accepted;
        if (!rst_n)
        begin
            start <= 1'b0;
            req   <= '0;
        end
        else
        begin
            accepted = start && !busy;
            if (accepted)
            begin
                rsp_expect_q.push_back(route_apply(req));
                op_count[req.op]++;
                txn_count++;
                void'(req_pending_q.pop_front());
            end
            if (start && !accepted)
            begin
                // hold the transaction until the block takes it
            end
            else if (req_pending_q.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                start <= 1'b1;
                req   <= req_pending_q[0];
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed response must match the oldest prediction.
    always @(posedge clk)
    begin : check_proc
        rte_pkg::route_rsp_t want;
        if (rst_n && $isunknown(done))
        begin
            report_mismatch("done is unknown");
        end
        else if (rst_n && done)
        begin
            if (rsp_expect_q.size() == 0)
            begin
                report_mismatch("response with no transaction outstanding");
            end
            else
            begin
                want = rsp_expect_q.pop_front();
                if (rsp.next_hop !== want.next_hop)
                    report_mismatch($sformatf("next_hop got %h want %h",
                                              rsp.next_hop, want.next_hop));
                if (rsp.hit !== want.hit)
                    report_mismatch($sformatf("hit got %b want %b", rsp.hit, want.hit));
                if (rsp.table_full !== want.table_full)
                    report_mismatch($sformatf("table_full got %b want %b",
                                              rsp.table_full, want.table_full));
                if (want.hit)
                    hit_count++;
                if (want.table_full)
                    full_count++;
            end
        end
    end

    initial
    begin
        int i;
        for (i = 0; i < ROUTE_ENTRIES; i++)
        begin
            route_dest[i] = '0;
            route_hop[i] = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, reserved destination, fill to full, scan order corners
        send_gap_pct = 32;
        push_req(rte_pkg::OP_LOOKUP,   8'h00, 8'h00);
        push_req(rte_pkg::OP_LOOKUP,   8'hFF, 8'hFF);
        push_req(rte_pkg::OP_ADD,      8'h00, 8'h05);
        push_req(rte_pkg::OP_DEL_DEST, 8'h00, 8'h00);
        push_req(rte_pkg::OP_DEL_HOP,  8'h00, 8'h00);
        push_req(rte_pkg::OP_ADD,      8'hFF, 8'hFF);
        push_req(rte_pkg::OP_ADD,      8'h01, 8'h00);
        push_req(rte_pkg::OP_ADD,      8'h80, 8'h01);
        push_req(rte_pkg::OP_ADD,      8'h7F, 8'hFE);
        push_req(rte_pkg::OP_ADD,      8'h55, 8'hAA);
        push_req(rte_pkg::OP_ADD,      8'hAA, 8'h55);
        push_req(rte_pkg::OP_ADD,      8'h10, 8'h01);
        push_req(rte_pkg::OP_ADD,      8'h20, 8'h01);
        push_req(rte_pkg::OP_ADD,      8'h33, 8'h03);
        push_req(rte_pkg::OP_ADD,      8'h80, 8'h42);
        push_req(rte_pkg::OP_LOOKUP,   8'h80, 8'h00);
        push_req(rte_pkg::OP_LOOKUP,   8'h01, 8'hFF);
        push_req(rte_pkg::OP_DEL_DEST, 8'h55, 8'h00);
        // refill the freed slot ahead of the existing entry: duplicate destination
        push_req(rte_pkg::OP_ADD,      8'hAA, 8'h77);
        push_req(rte_pkg::OP_LOOKUP,   8'hAA, 8'h00);
        push_req(rte_pkg::OP_DEL_DEST, 8'hAA, 8'h00);
        push_req(rte_pkg::OP_LOOKUP,   8'hAA, 8'h00);
        push_req(rte_pkg::OP_DEL_HOP,  8'h00, 8'h01);
        push_req(rte_pkg::OP_DEL_HOP,  8'h55, 8'h00);
        push_req(rte_pkg::OP_LOOKUP,   8'h01, 8'h00);

        queue_random(RANDOM_PER_PHASE);
        drain_requests();
        send_gap_pct = 88;
        queue_random(RANDOM_PER_PHASE);
        drain_requests();
        send_gap_pct = 0;
        queue_random(RANDOM_PER_PHASE);
        drain_requests();

        while (rsp_expect_q.size() != 0)
            @(negedge clk);
        repeat (4 * ROUTE_ENTRIES) @(negedge clk);

        $display("covered %0d transactions: %0d lookups, %0d adds, %0d dest deletes,",
                 txn_count, op_count[rte_pkg::OP_LOOKUP], op_count[rte_pkg::OP_ADD],
                 op_count[rte_pkg::OP_DEL_DEST]);
        $display("%0d hop purges; responses: %0d hits, %0d adds dropped on a full table, %0d mismatches",
                 op_count[rte_pkg::OP_DEL_HOP], hit_count, full_count, err_count);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/rte_pkg.sv
rtl/core/rte_ram.sv
rtl/core/rte_cmp.sv
rtl/core/routing_table_engine_unit.sv
test/tb_routing_table_engine_unit.sv
